// ===== rtl/core/ks_pkg.sv =====
// ----------------------------------------------------------------------------
// ks_pkg
// Shared types, scancode constants and character tables for the key stack.
// ----------------------------------------------------------------------------
package ks_pkg;

    localparam int ROM_LEN = 86;

    // Character tables, first character at the most significant byte.
    localparam logic [ROM_LEN*8-1:0] ROM_PLAIN =
        "__1234567890-=__qwertyuiop[]__asdfghjkl;'`_\\zxcvbnm,./_*______________________________";
    localparam logic [ROM_LEN*8-1:0] ROM_SHIFT =
        "__!@#$%^&*()_+__QWERTYUIOP{}__ASDFGHJKL:_~_|ZXCVBNM<>?_*______________________________";
    localparam logic [ROM_LEN*8-1:0] ROM_CAPS =
        "__1234567890-=__QWERTYUIOP[]__ASDFGHJKL;'`_\\ZXCVBNM,./_*______________________________";

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;

    localparam logic [7:0] SC_MINUS      = 8'd12;
    localparam logic [7:0] SC_LSHIFT     = 8'h2A;
    localparam logic [7:0] SC_RSHIFT     = 8'h36;
    localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
    localparam logic [7:0] SC_SPACE      = 8'h39;
    localparam logic [7:0] SC_ENTER      = 8'h1C;
    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
    localparam logic [7:0] SC_UP         = 8'h48;
    localparam logic [7:0] SC_DOWN       = 8'h50;
    localparam logic [7:0] SC_RIGHT      = 8'h4D;
    localparam logic [7:0] SC_LEFT       = 8'h4B;

    localparam logic [7:0] SPECIAL_BACKSPACE = 8'd0;
    localparam logic [7:0] SPECIAL_UP        = 8'd1;
    localparam logic [7:0] SPECIAL_DOWN      = 8'd2;
    localparam logic [7:0] SPECIAL_RIGHT     = 8'd3;
    localparam logic [7:0] SPECIAL_LEFT      = 8'd4;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_CHAR    = 2'd1;
    localparam logic [1:0] KIND_SPECIAL = 2'd2;

    // One queued command: a read, or a push of a 9-bit store entry.
    typedef struct packed {
        logic       is_read;
        logic [8:0] entry;
    } ks_cmd_t;

    function automatic logic [7:0] rom_char(input logic [ROM_LEN*8-1:0] rom,
                                            input logic [6:0] sc);
        logic [6:0] slot;
        slot = 7'(ROM_LEN - 1) - sc;
        return rom[{slot, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] lookup(input logic [7:0] sc,
                                          input logic shift,
                                          input logic caps);
        logic [7:0] ch;
        if (sc >= 8'(ROM_LEN)) begin
            ch = CH_UNDERSCORE;
        end else if (shift) begin
            ch = rom_char(ROM_SHIFT, sc[6:0]);
        end else if (caps) begin
            ch = rom_char(ROM_CAPS, sc[6:0]);
        end else begin
            ch = rom_char(ROM_PLAIN, sc[6:0]);
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/scancode_to_ascii_key_stack.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_key_stack
// Set 1 scancode to character translator feeding a wrapping key stack.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   command   in         start && !busy         op, scancode
//   result    out        strobe (one cycle)     kind, code
//
// The classifier is combinational; a push runs in the store engine's run
// state, while a read goes on to the read state, for the registered read port
// of the key memory, and the engine takes no new command until the read is done.
// After reset the engine clears the key memory, one entry a cycle, from the
// first entry through the last; busy stays high throughout that pass.
// busy is also high while the two-entry command queue is full.
// The receiver cannot stall: each result shows for exactly one cycle.
//
module scancode_to_ascii_key_stack
    import ks_pkg::*;
#(
    parameter int STORE_DEPTH = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       op,
    input  logic [7:0] scancode,
    output logic       strobe,
    output logic [1:0] kind,
    output logic [7:0] code
);

    logic    accept;
    logic    q_push;
    ks_cmd_t q_cmd;
    logic    q_pop;
    logic    q_empty;
    logic    q_full;
    ks_cmd_t q_head;
    logic    clearing;

    // A word is taken whenever the queue has room and the memory is ready.
    assign busy   = clearing || q_full;
    assign accept = start && !busy;

    // The classifier turns each word into a push, a read, or nothing, and
    // keeps the shift and caps lock flags in step with the word order.
    ks_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .op       (op),
        .scancode (scancode),
        .push     (q_push),
        .cmd      (q_cmd)
    );

    ks_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .empty    (q_empty),
        .full     (q_full),
        .head     (q_head)
    );

    // The engine runs commands in queue order, so results keep word order.
    ks_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .clearing (clearing),
        .strobe   (strobe),
        .kind     (kind),
        .code     (code)
    );

`ifndef SYNTHESIS
    // A read passes through the run and read states, so results never come back to back.
    assert property (@(posedge clk) disable iff (!rst_n) strobe |=> !strobe)
        else $error("results on consecutive cycles");

    // The queue never takes a command while it is full.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("push into a full queue");

    // Nothing is taken from the queue during the clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !q_pop)
        else $error("command run during clearing pass");

    // An empty result carries a zero code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && kind == KIND_NONE) |-> (code == 8'd0))
        else $error("empty result with nonzero code");
`endif

endmodule

// ===== rtl/core/ks_front.sv =====
// ----------------------------------------------------------------------------
// ks_front
// Classifies each accepted word and tracks the shift and caps lock flags.
// ----------------------------------------------------------------------------
module ks_front
    import ks_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       op,
    input  logic [7:0] scancode,
    output logic       push,
    output ks_cmd_t    cmd
);

    logic       shift_reg;
    logic       shift_next;
    logic       caps_reg;
    logic       caps_next;
    logic [7:0] ch;
    logic       emit;

    always_comb begin
        ch          = lookup(scancode, shift_reg, caps_reg);
        shift_next  = shift_reg;
        caps_next   = caps_reg;
        emit        = 1'b0;
        cmd.is_read = op;
        cmd.entry   = '0;
        if (op) begin
            emit = 1'b1;
        end else if (ch != CH_UNDERSCORE || scancode == SC_MINUS) begin
            emit      = 1'b1;
            cmd.entry = {1'b0, ch};
        end else begin
            unique case (scancode)
                SC_LSHIFT, SC_RSHIFT:         shift_next = 1'b1;
                SC_LSHIFT_REL, SC_RSHIFT_REL: shift_next = 1'b0;
                SC_CAPS:                      caps_next  = ~caps_reg;
                SC_SPACE:     begin emit = 1'b1; cmd.entry = {1'b0, CH_SPACE};   end
                SC_ENTER:     begin emit = 1'b1; cmd.entry = {1'b0, CH_NEWLINE}; end
                SC_BACKSPACE: begin emit = 1'b1; cmd.entry = {1'b1, SPECIAL_BACKSPACE}; end
                SC_UP:        begin emit = 1'b1; cmd.entry = {1'b1, SPECIAL_UP};    end
                SC_DOWN:      begin emit = 1'b1; cmd.entry = {1'b1, SPECIAL_DOWN};  end
                SC_RIGHT:     begin emit = 1'b1; cmd.entry = {1'b1, SPECIAL_RIGHT}; end
                SC_LEFT:      begin emit = 1'b1; cmd.entry = {1'b1, SPECIAL_LEFT};  end
                default:      emit = 1'b0;
            endcase
        end
        push = accept && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else if (accept)
        begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

// ===== rtl/core/ks_queue.sv =====
// ----------------------------------------------------------------------------
// ks_queue
// Two-entry command queue between the classifier and the store engine.
// ----------------------------------------------------------------------------
module ks_queue
    import ks_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  ks_cmd_t push_cmd,
    input  logic    pop,
    output logic    empty,
    output logic    full,
    output ks_cmd_t head
);

    ks_cmd_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/ks_back.sv =====
// ----------------------------------------------------------------------------
// ks_back
// Store engine: owns the key memory and the top pointer, runs queued pushes
// and reads, and clears the memory after reset.
// ----------------------------------------------------------------------------
module ks_back
    import ks_pkg::*;
#(
    parameter int STORE_DEPTH = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  ks_cmd_t    q_head,
    output logic       q_pop,
    output logic       clearing,
    output logic       strobe,
    output logic [1:0] kind,
    output logic [7:0] code
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_READ  = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] top_reg, top_next;
    logic          neg_reg, neg_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          was_neg_reg, was_neg_next;
    logic          strobe_reg, strobe_next;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    code_reg, code_next;

    logic [8:0]    mem [STORE_DEPTH];
    logic [8:0]    rdata_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [8:0]    wr_data;

    always_comb begin
        state_next   = state_reg;
        top_next     = top_reg;
        neg_next     = neg_reg;
        clr_next     = clr_reg;
        addr_next    = addr_reg;
        was_neg_next = was_neg_reg;
        strobe_next  = 1'b0;
        kind_next    = kind_reg;
        code_next    = code_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = neg_reg ? LAST : top_reg;
        wr_en        = 1'b0;
        wr_addr      = clr_reg;
        wr_data      = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en    = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_head.is_read) begin
                        rd_en        = 1'b1;
                        addr_next    = rd_addr;
                        was_neg_next = neg_reg;
                        state_next   = ST_READ;
                    end else begin
                        // The top wraps to the first slot past the end.
                        wr_en    = 1'b1;
                        wr_addr  = (neg_reg || top_reg == LAST) ? '0 : top_reg + AW'(1);
                        wr_data  = q_head.entry;
                        top_next = wr_addr;
                        neg_next = 1'b0;
                    end
                end
            end
            ST_READ: begin
                state_next  = ST_RUN;
                strobe_next = 1'b1;
                kind_next   = KIND_NONE;
                code_next   = '0;
                if (!(was_neg_reg && rdata_reg == '0)) begin
                    wr_en   = 1'b1;
                    wr_addr = addr_reg;
                    if (addr_reg == '0) begin
                        neg_next = 1'b1;
                    end else begin
                        top_next = addr_reg - AW'(1);
                        neg_next = 1'b0;
                    end
                    if (rdata_reg != '0) begin
                        kind_next = rdata_reg[8] ? KIND_SPECIAL : KIND_CHAR;
                        code_next = rdata_reg[7:0];
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            top_reg     <= '0;
            neg_reg     <= 1'b1;
            clr_reg     <= '0;
            was_neg_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            neg_reg     <= neg_next;
            clr_reg     <= clr_next;
            was_neg_reg <= was_neg_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        kind_reg <= kind_next;
        code_reg <= code_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign strobe   = strobe_reg;
    assign kind     = kind_reg;
    assign code     = code_reg;

endmodule
